### rtl/rfd_pkg.sv
package rfd_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned LenW  = 24;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PROTOCOL_VERSION     = 2'd0;
  localparam logic [1:0] REG_ATTACHMENT_FLAG_MASK = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME_SIZE       = 2'd2;
  localparam logic [1:0] REG_ATTACHMENT_CAPACITY  = 2'd3;

  localparam logic [7:0]      RST_PROTOCOL_VERSION     = 8'd1;
  localparam logic [7:0]      RST_ATTACHMENT_FLAG_MASK = 8'h80;
  localparam logic [LenW-1:0] RST_MAX_FRAME_SIZE       = 24'hFF_FFFF;
  localparam logic [LenW-1:0] RST_ATTACHMENT_CAPACITY  = 24'hFF_FFFF;

  localparam logic [LenW-1:0] INNER_HDR_BYTES = 24'd2;

  typedef enum logic [2:0] {
    PH_H0     = 3'd0,
    PH_H1     = 3'd1,
    PH_H2     = 3'd2,
    PH_H3     = 3'd3,
    PH_IN_LO  = 3'd4,
    PH_IN_HI  = 3'd5,
    PH_MSG    = 3'd6,
    PH_ATT    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_MESSAGE    = 2'd1,
    KIND_ATTACHMENT = 2'd2,
    KIND_DISCARD    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_SIZE    = 3'd2,
    ST_NO_INNER    = 3'd3,
    ST_MSG_OVER    = 3'd4,
    ST_ATT_OVER    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]      protocol_version;
    logic [7:0]      attachment_flag_mask;
    logic [LenW-1:0] max_frame_size;
    logic [LenW-1:0] attachment_capacity;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    kind_t           byte_kind;
    logic            frame_end;
    status_t         status;
    logic [LenW-1:0] message_length;
    logic [LenW-1:0] attachment_length;
  } result_t;

endpackage

### rtl/rfd_ifs.sv
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic        frame_end;
  logic [2:0]  status;
  logic [23:0] message_length;
  logic [23:0] attachment_length;

  modport source (output valid, output out_byte, output byte_kind, output frame_end,
                  output status, output message_length, output attachment_length,
                  input ready);
  modport sink (input valid, input out_byte, input byte_kind, input frame_end,
                input status, input message_length, input attachment_length,
                output ready);
endinterface

### rtl/rpc_frame_deframer.sv
// RPC frame deframer.
// The in_ch channel carries the connection stream, one byte per word. Each
// accepted word gives exactly one word on out_ch: the byte itself, its kind
// (header, message, attachment or discarded), a frame end mark, a status code
// and, on a clean frame end, the message and attachment lengths.
// A word accepted on in_ch is registered in the input stage, parsed from
// there and moved into the output register when that register is empty
// or being drained, and is then offered on out_ch. One word per cycle
// is taken for as long as the receiver keeps up; the rate is set by the
// single parse step between the input and output registers.
// When the receiver stalls, the output register holds its word and the input
// stage holds one more; in_ch.ready then falls until out_ch drains.
// Reset (rst, synchronous) empties both stages, returns the parser to the
// first header byte and loads the register defaults. A bad version or size
// halts the parser; every later byte is passed as discarded until reset.
// Registers are written over the APB port at byte addresses 0, 4, 8 and 12.
module rpc_frame_deframer (
  input  logic                      clk,
  input  logic                      rst,
  rfd_in_if.sink                    in_ch,
  rfd_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rfd_pkg::AddrW-1:0] paddr,
  input  logic [rfd_pkg::DataW-1:0] pwdata,
  output logic [rfd_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  rfd_pkg::cfg_t    cfg;
  rfd_pkg::result_t result;
  rfd_pkg::result_t out_word;

  logic       in_valid;
  logic [7:0] in_data;
  logic       out_valid;
  logic       advance;

  rfd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held byte moves to the output register whenever that register is
  // empty or being drained in the same cycle.
  assign advance     = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data <= in_ch.in_byte;
    end
  end

  rfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.out_byte          = out_word.out_byte;
  assign out_ch.byte_kind         = out_word.byte_kind;
  assign out_ch.frame_end         = out_word.frame_end;
  assign out_ch.status            = out_word.status;
  assign out_ch.message_length    = out_word.message_length;
  assign out_ch.attachment_length = out_word.attachment_length;

  // A status other than ok only appears on a frame end.
  a_status_only_at_end : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.frame_end |-> out_word.status == rfd_pkg::ST_OK)
    else $error("status set without frame end");

  // Lengths are reported only on error-free frame ends.
  a_len_only_when_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != rfd_pkg::ST_OK
      |-> out_word.message_length == '0 && out_word.attachment_length == '0)
    else $error("lengths reported on an error");

  // An empty output register never holds back the input.
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // After a halting header error, the next word offered is discarded.
  a_halt_discards : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.ready && out_word.frame_end &&
      (out_word.status == rfd_pkg::ST_BAD_VERSION ||
       out_word.status == rfd_pkg::ST_BAD_SIZE)
      |=> !out_valid || out_word.byte_kind == rfd_pkg::KIND_DISCARD)
    else $error("byte not discarded after halt");

endmodule

### rtl/rfd_apb_regs.sv
module rfd_apb_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rfd_pkg::AddrW-1:0] paddr,
  input  logic [rfd_pkg::DataW-1:0] pwdata,
  output logic [rfd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output rfd_pkg::cfg_t             cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version     <= rfd_pkg::RST_PROTOCOL_VERSION;
      cfg.attachment_flag_mask <= rfd_pkg::RST_ATTACHMENT_FLAG_MASK;
      cfg.max_frame_size       <= rfd_pkg::RST_MAX_FRAME_SIZE;
      cfg.attachment_capacity  <= rfd_pkg::RST_ATTACHMENT_CAPACITY;
    end else if (wr_en) begin
      unique case (reg_idx)
        rfd_pkg::REG_PROTOCOL_VERSION:     cfg.protocol_version     <= pwdata[7:0];
        rfd_pkg::REG_ATTACHMENT_FLAG_MASK: cfg.attachment_flag_mask <= pwdata[7:0];
        rfd_pkg::REG_MAX_FRAME_SIZE:       cfg.max_frame_size       <= pwdata[23:0];
        rfd_pkg::REG_ATTACHMENT_CAPACITY:  cfg.attachment_capacity  <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rfd_pkg::REG_PROTOCOL_VERSION:     prdata = {24'd0, cfg.protocol_version};
      rfd_pkg::REG_ATTACHMENT_FLAG_MASK: prdata = {24'd0, cfg.attachment_flag_mask};
      rfd_pkg::REG_MAX_FRAME_SIZE:       prdata = {8'd0, cfg.max_frame_size};
      rfd_pkg::REG_ATTACHMENT_CAPACITY:  prdata = {8'd0, cfg.attachment_capacity};
    endcase
  end

endmodule

### rtl/rfd_parser.sv
module rfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         in_byte,
  input  rfd_pkg::cfg_t      cfg,
  output rfd_pkg::result_t   result
);

  rfd_pkg::phase_t        phase, phase_next;
  logic                   att_present, att_present_next;
  logic [15:0]            size_lo, size_lo_next;
  logic [rfd_pkg::LenW-1:0] body_rem, body_rem_next;
  logic [rfd_pkg::LenW-1:0] msg_bytes, msg_bytes_next;
  logic [rfd_pkg::LenW-1:0] att_len, att_len_next;
  rfd_pkg::status_t       frame_err, frame_err_next;
  logic                   halted, halted_next;

  logic [rfd_pkg::LenW-1:0] body_dec;
  logic [rfd_pkg::LenW-1:0] size_full;
  logic [rfd_pkg::LenW-1:0] msg_full;
  logic [rfd_pkg::LenW-1:0] att_diff;
  logic                     msg_over;
  logic                     att_over;
  logic                     good_end;
  rfd_pkg::status_t         body_err;

  assign body_dec  = (body_rem == '0) ? '0 : body_rem - rfd_pkg::LenW'(1);
  assign size_full = {in_byte, size_lo};
  assign msg_full  = {8'd0, in_byte, msg_bytes[7:0]};
  assign att_diff  = body_dec - msg_full;
  assign msg_over  = msg_full > body_dec;
  assign att_over  = att_diff > cfg.attachment_capacity;

  always_comb begin
    phase_next       = phase;
    att_present_next = att_present;
    size_lo_next     = size_lo;
    body_rem_next    = body_rem;
    msg_bytes_next   = msg_bytes;
    att_len_next     = att_len;
    frame_err_next   = frame_err;
    halted_next      = halted;
    good_end         = 1'b0;
    body_err         = rfd_pkg::ST_OK;

    result.out_byte          = in_byte;
    result.byte_kind         = rfd_pkg::KIND_DISCARD;
    result.frame_end         = 1'b0;
    result.status            = rfd_pkg::ST_OK;
    result.message_length    = '0;
    result.attachment_length = '0;

    priority if (halted) begin
      // Everything is discarded until reset.
    end else if (frame_err != rfd_pkg::ST_OK) begin
      body_rem_next = body_dec;
      if (body_dec == '0) begin
        result.frame_end = 1'b1;
        result.status    = frame_err;
        frame_err_next   = rfd_pkg::ST_OK;
        phase_next       = rfd_pkg::PH_H0;
      end
    end else begin
      unique case (phase)
        rfd_pkg::PH_H0: begin
          result.byte_kind = rfd_pkg::KIND_HEADER;
          if ((in_byte & ~cfg.attachment_flag_mask) != cfg.protocol_version) begin
            result.status    = rfd_pkg::ST_BAD_VERSION;
            result.frame_end = 1'b1;
            halted_next      = 1'b1;
          end else begin
            att_present_next = |(in_byte & cfg.attachment_flag_mask);
            phase_next       = rfd_pkg::PH_H1;
          end
        end
        rfd_pkg::PH_H1: begin
          result.byte_kind = rfd_pkg::KIND_HEADER;
          size_lo_next     = {8'd0, in_byte};
          phase_next       = rfd_pkg::PH_H2;
        end
        rfd_pkg::PH_H2: begin
          result.byte_kind = rfd_pkg::KIND_HEADER;
          size_lo_next     = {in_byte, size_lo[7:0]};
          phase_next       = rfd_pkg::PH_H3;
        end
        rfd_pkg::PH_H3: begin
          result.byte_kind = rfd_pkg::KIND_HEADER;
          if (size_full == '0 || size_full > cfg.max_frame_size) begin
            result.status    = rfd_pkg::ST_BAD_SIZE;
            result.frame_end = 1'b1;
            halted_next      = 1'b1;
          end else begin
            body_rem_next  = size_full;
            msg_bytes_next = att_present ? '0 : size_full;
            att_len_next   = '0;
            phase_next     = att_present ? rfd_pkg::PH_IN_LO : rfd_pkg::PH_MSG;
          end
        end
        rfd_pkg::PH_IN_LO: begin
          if (body_rem < rfd_pkg::INNER_HDR_BYTES) begin
            result.status    = rfd_pkg::ST_NO_INNER;
            result.frame_end = 1'b1;
            body_rem_next    = '0;
            phase_next       = rfd_pkg::PH_H0;
          end else begin
            result.byte_kind = rfd_pkg::KIND_HEADER;
            msg_bytes_next   = {16'd0, in_byte};
            body_rem_next    = body_dec;
            phase_next       = rfd_pkg::PH_IN_HI;
          end
        end
        rfd_pkg::PH_IN_HI: begin
          result.byte_kind = rfd_pkg::KIND_HEADER;
          msg_bytes_next   = msg_full;
          body_rem_next    = body_dec;
          att_len_next     = att_diff;
          if (msg_over) begin
            body_err = rfd_pkg::ST_MSG_OVER;
          end else if (att_over) begin
            body_err = rfd_pkg::ST_ATT_OVER;
          end
          if (body_err != rfd_pkg::ST_OK) begin
            phase_next = rfd_pkg::PH_H0;
            if (body_dec == '0) begin
              result.frame_end = 1'b1;
              result.status    = body_err;
            end else begin
              frame_err_next = body_err;
            end
          end else if (body_dec == '0) begin
            good_end = 1'b1;
          end else begin
            phase_next = (msg_full != '0) ? rfd_pkg::PH_MSG : rfd_pkg::PH_ATT;
          end
        end
        rfd_pkg::PH_MSG: begin
          result.byte_kind = rfd_pkg::KIND_MESSAGE;
          body_rem_next    = body_dec;
          if (body_dec == '0) begin
            good_end = 1'b1;
          end else if (body_dec <= att_len) begin
            phase_next = rfd_pkg::PH_ATT;
          end
        end
        rfd_pkg::PH_ATT: begin
          result.byte_kind = rfd_pkg::KIND_ATTACHMENT;
          body_rem_next    = body_dec;
          if (body_dec == '0) begin
            good_end = 1'b1;
          end
        end
      endcase
      if (good_end) begin
        // On an early end in the inner header both lengths are zero.
        result.frame_end         = 1'b1;
        result.message_length    = msg_bytes_next;
        result.attachment_length = att_len;
        phase_next               = rfd_pkg::PH_H0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rfd_pkg::PH_H0;
      att_present <= 1'b0;
      size_lo     <= '0;
      body_rem    <= '0;
      msg_bytes   <= '0;
      att_len     <= '0;
      frame_err   <= rfd_pkg::ST_OK;
      halted      <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      att_present <= att_present_next;
      size_lo     <= size_lo_next;
      body_rem    <= body_rem_next;
      msg_bytes   <= msg_bytes_next;
      att_len     <= att_len_next;
      frame_err   <= frame_err_next;
      halted      <= halted_next;
    end
  end

endmodule

### tb/sv/rpc_frame_deframer_tb.sv
`timescale 1ns / 1ps

module rpc_frame_deframer_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_WORDS    = 86;

  logic                         clk;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rfd_pkg::AddrW-1:0]    paddr;
  logic [rfd_pkg::DataW-1:0]    pwdata;
  logic [rfd_pkg::DataW-1:0]    prdata;
  logic                         pready;

  rfd_in_if  in_ch ();
  rfd_out_if out_ch ();

  rpc_frame_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copy and parser state of the prediction. They change only when
  // a word is accepted on in_ch or a register write completes.
  rfd_pkg::cfg_t    cfg;
  rfd_pkg::phase_t  parse_phase   = rfd_pkg::PH_H0;
  bit               att_flag      = 1'b0;
  int unsigned      body_size     = 0;
  int unsigned      body_left     = 0;
  int unsigned      msg_len       = 0;
  rfd_pkg::status_t pending_err   = rfd_pkg::ST_OK;
  bit               parser_halted = 1'b0;

  // Labelled words that the block still owes us, oldest first.
  rfd_pkg::result_t predicted_words[$];

  // Largest idle gap that each side draws before a word; zero means the
  // side runs flat out. rx_hold asks the receiver for one long stall.
  int tx_max_gap = 16;
  int rx_max_gap = 16;
  int rx_hold    = 0;

  int    errors      = 0;
  int    words_in    = 0;
  int    words_out   = 0;
  int    clean_ends  = 0;
  int    error_ends  = 0;
  string halt_case   = "";

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(input int max_gap);
    return (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
  endfunction

  // Attachment length implied by the frame size and the message size; zero
  // when there is no attachment or the message already fills the body.
  function automatic int unsigned attach_bytes();
    int unsigned used;
    used = msg_len + 2;
    if (!att_flag || used > body_size) return 0;
    return (body_size - used) & 32'hFF_FFFF;
  endfunction

  // Labels one stream byte and advances the parser state.
  function automatic rfd_pkg::result_t label_byte(input logic [7:0] b);
    rfd_pkg::result_t r;
    rfd_pkg::status_t err;
    bit               good_end;
    r = '0;
    r.out_byte = b;
    r.byte_kind = rfd_pkg::KIND_DISCARD;
    r.status = rfd_pkg::ST_OK;
    err = rfd_pkg::ST_OK;
    good_end = 1'b0;
    if (parser_halted) begin
      // After a header error everything is discarded until reset.
    end else if (pending_err != rfd_pkg::ST_OK) begin
      // The tail of a frame with a body error; its last byte reports it.
      if (body_left != 0) body_left--;
      if (body_left == 0) begin
        r.frame_end = 1'b1;
        r.status = pending_err;
        pending_err = rfd_pkg::ST_OK;
        parse_phase = rfd_pkg::PH_H0;
      end
    end else begin
      case (parse_phase)
        rfd_pkg::PH_H0: begin
          r.byte_kind = rfd_pkg::KIND_HEADER;
          if ((b & ~cfg.attachment_flag_mask) != cfg.protocol_version) begin
            r.status = rfd_pkg::ST_BAD_VERSION;
            r.frame_end = 1'b1;
            parser_halted = 1'b1;
          end else begin
            att_flag = (b & cfg.attachment_flag_mask) != 0;
            body_size = 0;
            parse_phase = rfd_pkg::PH_H1;
          end
        end
        rfd_pkg::PH_H1: begin
          r.byte_kind = rfd_pkg::KIND_HEADER;
          body_size = 32'(b);
          parse_phase = rfd_pkg::PH_H2;
        end
        rfd_pkg::PH_H2: begin
          r.byte_kind = rfd_pkg::KIND_HEADER;
          body_size = body_size | (32'(b) << 8);
          parse_phase = rfd_pkg::PH_H3;
        end
        rfd_pkg::PH_H3: begin
          r.byte_kind = rfd_pkg::KIND_HEADER;
          body_size = (body_size | (32'(b) << 16)) & 32'hFF_FFFF;
          if (body_size == 0 || body_size > cfg.max_frame_size) begin
            r.status = rfd_pkg::ST_BAD_SIZE;
            r.frame_end = 1'b1;
            parser_halted = 1'b1;
          end else begin
            body_left = body_size;
            msg_len = att_flag ? 0 : body_size;
            parse_phase = att_flag ? rfd_pkg::PH_IN_LO : rfd_pkg::PH_MSG;
          end
        end
        rfd_pkg::PH_IN_LO: begin
          if (body_left < 2) begin
            // A one byte body cannot hold the inner length.
            r.status = rfd_pkg::ST_NO_INNER;
            r.frame_end = 1'b1;
            body_left = 0;
            parse_phase = rfd_pkg::PH_H0;
          end else begin
            r.byte_kind = rfd_pkg::KIND_HEADER;
            msg_len = 32'(b);
            body_left--;
            parse_phase = rfd_pkg::PH_IN_HI;
          end
        end
        rfd_pkg::PH_IN_HI: begin
          r.byte_kind = rfd_pkg::KIND_HEADER;
          msg_len = msg_len | (32'(b) << 8);
          if (body_left != 0) body_left--;
          if (msg_len > body_left) err = rfd_pkg::ST_MSG_OVER;
          else if (body_left - msg_len > cfg.attachment_capacity) err = rfd_pkg::ST_ATT_OVER;
          if (err != rfd_pkg::ST_OK) begin
            parse_phase = rfd_pkg::PH_H0;
            if (body_left == 0) begin
              r.frame_end = 1'b1;
              r.status = err;
            end else begin
              pending_err = err;
            end
          end else if (body_left == 0) begin
            good_end = 1'b1;
          end else begin
            parse_phase = (msg_len != 0) ? rfd_pkg::PH_MSG : rfd_pkg::PH_ATT;
          end
        end
        rfd_pkg::PH_MSG: begin
          r.byte_kind = rfd_pkg::KIND_MESSAGE;
          if (body_left != 0) body_left--;
          if (body_left == 0) good_end = 1'b1;
          else if (body_left <= attach_bytes()) parse_phase = rfd_pkg::PH_ATT;
        end
        default: begin
          r.byte_kind = rfd_pkg::KIND_ATTACHMENT;
          if (body_left != 0) body_left--;
          if (body_left == 0) good_end = 1'b1;
        end
      endcase
      if (good_end) begin
        r.frame_end = 1'b1;
        r.message_length = msg_len[23:0];
        r.attachment_length = 24'(attach_bytes());
        parse_phase = rfd_pkg::PH_H0;
      end
    end
    return r;
  endfunction

  // Offers one byte after a random gap and holds it until it is taken. The
  // valid line is only lowered when a gap follows, so back to back words
  // never see valid fall and rise within one time step.
  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predicted_words.push_back(label_byte(b));
    words_in++;
  endtask

  // Sends a whole frame: header byte zero, the 24-bit size, then the body.
  // A non-negative inner value goes out as the 2-byte inner length at the
  // start of the body; the rest of the body is random.
  task automatic send_frame(input logic [7:0] lead, input int body, input int inner);
    send_word(lead);
    send_word(body[7:0]);
    send_word(body[15:8]);
    send_word(body[23:16]);
    for (int i = 0; i < body; i++) begin
      if (inner >= 0 && body >= 2 && i == 0) send_word(inner[7:0]);
      else if (inner >= 0 && body >= 2 && i == 1) send_word(inner[15:8]);
      else send_word(8'($urandom_range(255, 0)));
    end
  endtask

  // Header byte zero for the current register setting, with a random
  // nonzero part of the flag mask when an attachment is wanted.
  function automatic logic [7:0] lead_byte(input bit with_att);
    logic [7:0] flag;
    flag = 8'($urandom_range(255, 1)) & cfg.attachment_flag_mask;
    if (flag == 8'h00) flag = cfg.attachment_flag_mask;
    return cfg.protocol_version | (with_att ? flag : 8'h00);
  endfunction

  // Drops valid and waits until every predicted word has come back. Each
  // accepted word yields one result, so the block is idle after that.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes one register, then reads it back. Only called while idle.
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
    logic [rfd_pkg::DataW-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= rfd_pkg::DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      rfd_pkg::REG_PROTOCOL_VERSION: begin
        cfg.protocol_version = value[7:0];
        want = rfd_pkg::DataW'(value[7:0]);
      end
      rfd_pkg::REG_ATTACHMENT_FLAG_MASK: begin
        cfg.attachment_flag_mask = value[7:0];
        want = rfd_pkg::DataW'(value[7:0]);
      end
      rfd_pkg::REG_MAX_FRAME_SIZE: begin
        cfg.max_frame_size = value;
        want = rfd_pkg::DataW'(value);
      end
      default: begin
        cfg.attachment_capacity = value;
        want = rfd_pkg::DataW'(value);
      end
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read back: expected %0h, got %0h",
               $time, idx, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Clean frames with the reset settings: a plain one byte message, an empty
  // message and attachment that end on the inner header, one message byte
  // followed by one attachment byte, and an attachment with no message.
  task automatic test_clean_frames();
    send_frame(lead_byte(1'b0), 1, -1);
    send_frame(lead_byte(1'b1), 2, 0);
    send_frame(lead_byte(1'b1), 4, 1);
    send_frame(lead_byte(1'b1), 3, 0);
    wait_quiet();
  endtask

  // Body errors: no room for the inner header, a message length that
  // overflows a two byte body (reported on the inner header itself), and an
  // overflow that leaves a tail of discarded bytes.
  task automatic test_body_errors();
    send_frame(lead_byte(1'b1), 1, 0);
    send_frame(lead_byte(1'b1), 2, 16'hFFFF);
    send_frame(lead_byte(1'b1), 5, 4);
    wait_quiet();
  endtask

  // Every register at its extremes, with a frame or two under each setting.
  task automatic test_register_extremes();
    // No attachment room at all: one attachment byte is too many, none fits.
    write_reg(rfd_pkg::REG_ATTACHMENT_CAPACITY, 24'd0);
    send_frame(lead_byte(1'b1), 3, 0);
    send_frame(lead_byte(1'b1), 3, 1);
    wait_quiet();
    // No flag bits: byte zero must match the version exactly.
    write_reg(rfd_pkg::REG_ATTACHMENT_FLAG_MASK, 24'd0);
    write_reg(rfd_pkg::REG_PROTOCOL_VERSION, 24'd255);
    send_frame(lead_byte(1'b0), 1, -1);
    wait_quiet();
    // Every bit is a flag bit, so version zero accepts any byte zero.
    write_reg(rfd_pkg::REG_ATTACHMENT_FLAG_MASK, 24'd255);
    write_reg(rfd_pkg::REG_PROTOCOL_VERSION, 24'd0);
    write_reg(rfd_pkg::REG_ATTACHMENT_CAPACITY, 24'hFF_FFFF);
    send_frame(lead_byte(1'b1), 3, 1);
    wait_quiet();
    // Smallest frame limit: only a one byte body is allowed.
    write_reg(rfd_pkg::REG_ATTACHMENT_FLAG_MASK, 24'h80);
    write_reg(rfd_pkg::REG_PROTOCOL_VERSION, 24'd1);
    write_reg(rfd_pkg::REG_MAX_FRAME_SIZE, 24'd1);
    send_frame(lead_byte(1'b0), 1, -1);
    send_frame(lead_byte(1'b1), 1, 0);
    wait_quiet();
    write_reg(rfd_pkg::REG_MAX_FRAME_SIZE, 24'hFF_FFFF);
  endtask

  // The receiver stalls for a long stretch while the sender keeps pushing,
  // so both stages fill and in_ch.ready drops. The sender then pauses until
  // every predicted word has drained.
  task automatic test_back_pressure();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold = 300;
    send_frame(lead_byte(1'b1), 20, 7);
    send_frame(lead_byte(1'b0), 18, -1);
    send_frame(lead_byte(1'b1), 22, 30);
    wait_quiet();
    tx_max_gap = 16;
    rx_max_gap = 16;
  endtask

  // Mostly well formed frames with random sizes and content under random
  // register settings, plus frames broken in each recoverable way. Header
  // errors are left out here since they halt the block for good.
  task automatic test_random_traffic();
    int  pick;
    int  msg;
    int  att;
    int  target;
    bit  with_att;
    logic [7:0] mask;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      mask = 8'($urandom_range(255, 1));
      if ($urandom_range(2, 0) == 0) mask = 8'h80;
      write_reg(rfd_pkg::REG_ATTACHMENT_FLAG_MASK, 24'(mask));
      write_reg(rfd_pkg::REG_PROTOCOL_VERSION, 24'($urandom_range(255, 0) & ~mask));
      write_reg(rfd_pkg::REG_MAX_FRAME_SIZE,
                $urandom_range(1, 0) ? 24'hFF_FFFF : 24'($urandom_range(4095, 64)));
      write_reg(rfd_pkg::REG_ATTACHMENT_CAPACITY,
                $urandom_range(1, 0) ? 24'hFF_FFFF : 24'($urandom_range(24, 0)));
      // Idle patterns rotate so that some phases run with no gaps at all.
      tx_max_gap = (ph % 4 == 1 || ph % 4 == 3) ? 0 : 16;
      rx_max_gap = (ph % 4 == 2 || ph % 4 == 3) ? 0 : 16;
      target = words_in + PHASE_WORDS;
      while (words_in < target) begin
        pick = $urandom_range(99, 0);
        with_att = $urandom_range(1, 0);
        msg = $urandom_range(24, 0);
        att = $urandom_range(24, 0);
        if (pick < 75) begin
          if (with_att) begin
            if (att > cfg.attachment_capacity) att = int'(cfg.attachment_capacity);
            send_frame(lead_byte(1'b1), msg + att + 2, msg);
          end else begin
            send_frame(lead_byte(1'b0), (msg == 0) ? 1 : msg, -1);
          end
        end else if (pick < 93) begin
          if (pick >= 85 && cfg.attachment_capacity < 30) begin
            // Attachment just over the capacity.
            att = int'(cfg.attachment_capacity) + 1 + $urandom_range(3, 0);
            send_frame(lead_byte(1'b1), msg + att + 2, msg);
          end else begin
            // Inner length longer than what is left of the body.
            send_frame(lead_byte(1'b1), msg + att + 2,
                       $urandom_range(65535, msg + att + 1));
          end
        end else begin
          send_frame(lead_byte(1'b1), 1, 0);
        end
      end
    end
    wait_quiet();
    tx_max_gap = 16;
    rx_max_gap = 16;
  endtask

  // A header error halts the block until reset, so only one of the two can
  // be seen per run; the seed picks which. Later bytes must all come back
  // discarded.
  task automatic test_halt();
    write_reg(rfd_pkg::REG_ATTACHMENT_FLAG_MASK, 24'h80);
    write_reg(rfd_pkg::REG_PROTOCOL_VERSION, 24'd1);
    if ($urandom_range(1, 0)) begin
      halt_case = "version";
      send_word(8'hFF);
    end else begin
      halt_case = "size";
      write_reg(rfd_pkg::REG_MAX_FRAME_SIZE, 24'd16);
      send_word(lead_byte(1'($urandom_range(1, 0))));
      if ($urandom_range(1, 0)) begin
        repeat (3) send_word(8'h00);
      end else begin
        repeat (3) send_word(8'hFF);
      end
    end
    repeat (12) send_word(8'($urandom_range(255, 0)));
    wait_quiet();
  endtask

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Every word taken from out_ch is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    rfd_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (out_ch.frame_end) begin
        if (out_ch.status == rfd_pkg::ST_OK) clean_ends++;
        else error_ends++;
      end
      if (predicted_words.size() == 0) begin
        errors++;
        $display("%0t: word %0h arrived with nothing predicted", $time, out_ch.out_byte);
      end else begin
        want = predicted_words.pop_front();
        check_field("out_byte", 24'(want.out_byte), 24'(out_ch.out_byte));
        check_field("byte_kind", 24'(want.byte_kind), 24'(out_ch.byte_kind));
        check_field("frame_end", 24'(want.frame_end), 24'(out_ch.frame_end));
        check_field("status", 24'(want.status), 24'(out_ch.status));
        check_field("message_length", want.message_length, out_ch.message_length);
        check_field("attachment_length", want.attachment_length,
                    out_ch.attachment_length);
      end
    end
  end

  // The receiver draws a stall before each word, or takes the long hold
  // when a test asks for one. Ready only drops when a stall follows.
  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = draw_gap(rx_max_gap);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Ends the run if no word and no register access moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("rpc_frame_deframer_tb: done, errors");
    $finish;
  end

  initial begin : main
    cfg.protocol_version = rfd_pkg::RST_PROTOCOL_VERSION;
    cfg.attachment_flag_mask = rfd_pkg::RST_ATTACHMENT_FLAG_MASK;
    cfg.max_frame_size = rfd_pkg::RST_MAX_FRAME_SIZE;
    cfg.attachment_capacity = rfd_pkg::RST_ATTACHMENT_CAPACITY;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_clean_frames();
    test_body_errors();
    test_register_extremes();
    test_back_pressure();
    test_random_traffic();
    test_halt();

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("Sent %0d words and checked %0d: %0d clean frame ends, %0d error ends.",
             words_in, words_out, clean_ends, error_ends);
    $display("Registers were swept to their extremes; the run ended on a bad %s halt.",
             halt_case);
    if (errors == 0) begin
      $display("rpc_frame_deframer_tb: done, clean");
    end else begin
      $display("rpc_frame_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
